// ===== rtl/fbc_pkg.sv =====
// Shared constants, types and helpers for the FIFO block cache.
package fbc_pkg;

    // Default sizing
    localparam int MAX_SLOTS_DEF   = 64;
    localparam int BLOCK_WORDS_DEF = 32;

    // Field widths fixed by the interface
    localparam int DISK_W  = 4;
    localparam int BLOCK_W = 8;
    localparam int INDEX_W = 5;
    localparam int WORD_W  = 64;
    localparam int CFG_W   = 7;

    // Operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_OFF  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SLOTS  = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_STREAM,
        S_RESP
    } state_t;

    // One tag memory entry
    typedef struct packed {
        logic               valid;
        logic [DISK_W-1:0]  disk;
        logic [BLOCK_W-1:0] block;
    } tag_ent_t;

    // Controller to tag store
    typedef struct packed {
        logic               clear;
        logic               start;
        logic               wr_en;
        logic [DISK_W-1:0]  disk;
        logic [BLOCK_W-1:0] block;
    } scan_ctl_t;

    // Tag store to controller
    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } scan_rsp_t;

    // Slot count actually used: clamped to 2..max_slots
    function automatic int clamp_slots(input logic [CFG_W-1:0] v, input int max_slots);
        int r;
        r = int'(v);
        if (r < 2) begin
            r = 2;
        end
        if (r > max_slots) begin
            r = max_slots;
        end
        return r;
    endfunction

endpackage

// ===== rtl/fifo_block_cache.sv =====
// Lookup: a sequential tag memory scan finds the matching slot, then the block streams
//   one word per cycle while the output does not stall; a miss answers once the
//   scan has covered the slots in use. Insert/update word 0 scans the same way; later
//   words answer from the word-0 decision without a scan. One item is handled at a time.
// After reset and after every configuration write, a clearing pass sweeps all MAX_SLOTS
//   tag memory entries; no transfer is accepted meanwhile.
module fifo_block_cache #(
    parameter int MAX_SLOTS   = fbc_pkg::MAX_SLOTS_DEF,
    parameter int BLOCK_WORDS = fbc_pkg::BLOCK_WORDS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [fbc_pkg::CFG_W-1:0]    cfg_wdata,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [fbc_pkg::DISK_W-1:0]   s_disk,
    input  logic [fbc_pkg::BLOCK_W-1:0]  s_block_id,
    input  logic [fbc_pkg::INDEX_W-1:0]  s_word_index,
    input  logic [fbc_pkg::WORD_W-1:0]   s_data_word,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [fbc_pkg::WORD_W-1:0]   m_out_word,
    output logic [fbc_pkg::INDEX_W-1:0]  m_out_index,
    output logic                         m_last
);

    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int KW  = $clog2(BLOCK_WORDS + 1);
    localparam int DAW = $clog2(MAX_SLOTS * BLOCK_WORDS);
    localparam int IW  = fbc_pkg::INDEX_W;
    localparam int WW  = fbc_pkg::WORD_W;
    localparam logic LAST_W0 = (BLOCK_WORDS == 1);

    // Data memory address of a word in a slot
    function automatic logic [DAW-1:0] data_addr(input logic [SW-1:0] slot,
                                                 input logic [IW-1:0] idx);
        return DAW'(32'(slot) * 32'(BLOCK_WORDS) + 32'(idx));
    endfunction

    fbc_pkg::state_t state_reg, state_next;

    // Captured item
    logic [1:0]                  op_reg, op_next;
    logic [fbc_pkg::DISK_W-1:0]  disk_reg, disk_next;
    logic [fbc_pkg::BLOCK_W-1:0] block_reg, block_next;
    logic [IW-1:0]               widx_reg, widx_next;
    logic [WW-1:0]               data_reg, data_next;

    // Configuration and cache control state
    logic          enable_reg, enable_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] ptr_reg, ptr_next;
    logic [SW-1:0] pend_slot_reg, pend_slot_next;
    logic [1:0]    pend_st_reg, pend_st_next;
    logic          pend_ok_reg, pend_ok_next;

    // Lookup streaming
    logic [DAW-1:0] base_reg, base_next;
    logic [KW-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [KW-1:0]  ld_cnt_reg, ld_cnt_next;
    logic           dav_reg, dav_next;

    // Held single result
    logic [1:0]    res_st_reg, res_st_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;
    logic          res_last_reg, res_last_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [WW-1:0] m_word_reg, m_word_next;
    logic [IW-1:0] m_index_reg, m_index_next;
    logic          m_last_reg, m_last_next;

    // Memory and tag store hookups
    fbc_pkg::scan_ctl_t scan_ctl;
    fbc_pkg::scan_rsp_t scan_rsp;
    logic [SW-1:0]  hit_slot;
    logic [SW-1:0]  tag_wr_slot;
    logic           dram_we;
    logic [DAW-1:0] dram_waddr;
    logic [WW-1:0]  dram_wdata;
    logic           dram_re;
    logic [DAW-1:0] dram_raddr;
    logic [WW-1:0]  dram_rdata;

    // Combinational helpers
    logic          s_fire;
    logic          out_free;
    logic          r_vld;
    logic [1:0]    r_st;
    logic [IW-1:0] r_idx;
    logic          r_last;
    logic          w_load;
    logic          w_issue;
    logic          cfg_clear;
    logic [SW-1:0] ins_slot;
    logic [CW-1:0] ins_inc;

    assign s_ready  = (state_reg == fbc_pkg::S_IDLE) && !scan_rsp.busy && !cfg_wr_en;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // FIFO slot for an insert and its successor
    assign ins_slot = (CW'(ptr_reg) < n_reg) ? ptr_reg : '0;
    assign ins_inc  = CW'(ins_slot) + CW'(1);

    fbc_tag_scan #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_tag_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (scan_ctl),
        .wr_slot  (tag_wr_slot),
        .n_slots  (n_reg),
        .rsp      (scan_rsp),
        .hit_slot (hit_slot)
    );

    fbc_data_ram #(
        .DEPTH (MAX_SLOTS * BLOCK_WORDS),
        .WIDTH (WW)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (dram_we),
        .wr_addr (dram_waddr),
        .wr_data (dram_wdata),
        .rd_en   (dram_re),
        .rd_addr (dram_raddr),
        .rd_data (dram_rdata)
    );

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fbc_pkg::S_IDLE;
            enable_reg    <= 1'b0;
            n_reg         <= CW'(fbc_pkg::clamp_slots(fbc_pkg::SLOTS_RESET, MAX_SLOTS));
            ptr_reg       <= '0;
            pend_slot_reg <= '0;
            pend_st_reg   <= fbc_pkg::ST_OK;
            pend_ok_reg   <= 1'b0;
            rd_cnt_reg    <= '0;
            ld_cnt_reg    <= '0;
            dav_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            n_reg         <= n_next;
            ptr_reg       <= ptr_next;
            pend_slot_reg <= pend_slot_next;
            pend_st_reg   <= pend_st_next;
            pend_ok_reg   <= pend_ok_next;
            rd_cnt_reg    <= rd_cnt_next;
            ld_cnt_reg    <= ld_cnt_next;
            dav_reg       <= dav_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        disk_reg     <= disk_next;
        block_reg    <= block_next;
        widx_reg     <= widx_next;
        data_reg     <= data_next;
        base_reg     <= base_next;
        res_st_reg   <= res_st_next;
        res_idx_reg  <= res_idx_next;
        res_last_reg <= res_last_next;
        m_status_reg <= m_status_next;
        m_word_reg   <= m_word_next;
        m_index_reg  <= m_index_next;
        m_last_reg   <= m_last_next;
    end

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        disk_next      = disk_reg;
        block_next     = block_reg;
        widx_next      = widx_reg;
        data_next      = data_reg;
        enable_next    = enable_reg;
        n_next         = n_reg;
        ptr_next       = ptr_reg;
        pend_slot_next = pend_slot_reg;
        pend_st_next   = pend_st_reg;
        pend_ok_next   = pend_ok_reg;
        base_next      = base_reg;
        rd_cnt_next    = rd_cnt_reg;
        ld_cnt_next    = ld_cnt_reg;
        dav_next       = dav_reg;
        res_st_next    = res_st_reg;
        res_idx_next   = res_idx_reg;
        res_last_next  = res_last_reg;
        m_status_next  = m_status_reg;
        m_word_next    = m_word_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        scan_ctl.clear = 1'b0;
        scan_ctl.start = 1'b0;
        scan_ctl.wr_en = 1'b0;
        scan_ctl.disk  = disk_reg;
        scan_ctl.block = block_reg;
        tag_wr_slot    = ins_slot;

        dram_we    = 1'b0;
        dram_waddr = data_addr(pend_slot_reg, s_word_index);
        dram_wdata = s_data_word;
        dram_re    = 1'b0;
        dram_raddr = base_reg + DAW'(rd_cnt_reg);

        r_vld   = 1'b0;
        r_st    = fbc_pkg::ST_OK;
        r_idx   = '0;
        r_last  = 1'b1;
        w_load  = 1'b0;
        w_issue = 1'b0;
        cfg_clear = 1'b0;

        case (state_reg)
            fbc_pkg::S_IDLE: begin
                if (s_fire) begin
                    op_next    = s_op;
                    disk_next  = s_disk;
                    block_next = s_block_id;
                    widx_next  = s_word_index;
                    data_next  = s_data_word;
                    if (!enable_reg) begin
                        r_vld = 1'b1;
                        r_st  = fbc_pkg::ST_OFF;
                    end else if (s_op == fbc_pkg::OP_LOOKUP) begin
                        scan_ctl.start = 1'b1;
                        state_next     = fbc_pkg::S_SCAN;
                    end else if (!(s_op inside {fbc_pkg::OP_INSERT, fbc_pkg::OP_UPDATE})) begin
                        r_vld = 1'b1;
                        r_st  = fbc_pkg::ST_MISS;
                    end else if (32'(s_word_index) >= 32'(BLOCK_WORDS)) begin
                        // word beyond the block: report only
                        r_vld  = 1'b1;
                        r_st   = pend_st_reg;
                        r_idx  = s_word_index;
                        r_last = 1'b0;
                    end else if (s_word_index == '0) begin
                        scan_ctl.start = 1'b1;
                        state_next     = fbc_pkg::S_SCAN;
                    end else begin
                        // later word follows the word-0 decision
                        dram_we = pend_ok_reg;
                        r_vld   = 1'b1;
                        r_st    = pend_st_reg;
                        r_idx   = s_word_index;
                        r_last  = (32'(s_word_index) == 32'(BLOCK_WORDS - 1));
                    end
                end
            end

            fbc_pkg::S_SCAN: begin
                if (scan_rsp.done) begin
                    dram_wdata = data_reg;
                    if (op_reg == fbc_pkg::OP_LOOKUP) begin
                        if (scan_rsp.hit) begin
                            base_next   = data_addr(hit_slot, '0);
                            rd_cnt_next = '0;
                            ld_cnt_next = '0;
                            dav_next    = 1'b0;
                            state_next  = fbc_pkg::S_STREAM;
                        end else begin
                            r_vld = 1'b1;
                            r_st  = fbc_pkg::ST_MISS;
                        end
                    end else if (op_reg == fbc_pkg::OP_INSERT) begin
                        if (scan_rsp.hit) begin
                            pend_st_next = fbc_pkg::ST_DUP;
                            pend_ok_next = 1'b0;
                        end else begin
                            // take the FIFO slot and install the tag
                            scan_ctl.wr_en = 1'b1;
                            dram_we        = 1'b1;
                            dram_waddr     = data_addr(ins_slot, '0);
                            ptr_next       = (ins_inc >= n_reg) ? '0 : ins_inc[SW-1:0];
                            pend_slot_next = ins_slot;
                            pend_st_next   = fbc_pkg::ST_OK;
                            pend_ok_next   = 1'b1;
                        end
                        r_vld  = 1'b1;
                        r_st   = scan_rsp.hit ? fbc_pkg::ST_DUP : fbc_pkg::ST_OK;
                        r_last = LAST_W0;
                    end else begin
                        if (scan_rsp.hit) begin
                            dram_we        = 1'b1;
                            dram_waddr     = data_addr(hit_slot, '0);
                            pend_slot_next = hit_slot;
                            pend_st_next   = fbc_pkg::ST_OK;
                            pend_ok_next   = 1'b1;
                        end else begin
                            pend_st_next = fbc_pkg::ST_MISS;
                            pend_ok_next = 1'b0;
                        end
                        r_vld  = 1'b1;
                        r_st   = scan_rsp.hit ? fbc_pkg::ST_OK : fbc_pkg::ST_MISS;
                        r_last = LAST_W0;
                    end
                end
            end

            fbc_pkg::S_STREAM: begin
                // one word per cycle while the output does not stall; memory output holds while stalled
                w_load  = dav_reg && out_free;
                w_issue = (32'(rd_cnt_reg) < 32'(BLOCK_WORDS)) && (!dav_reg || w_load);
                dram_re = w_issue;
                if (w_issue) begin
                    rd_cnt_next = rd_cnt_reg + KW'(1);
                    dav_next    = 1'b1;
                end else if (w_load) begin
                    dav_next = 1'b0;
                end
                if (w_load) begin
                    m_valid_next  = 1'b1;
                    m_status_next = fbc_pkg::ST_OK;
                    m_word_next   = dram_rdata;
                    m_index_next  = IW'(ld_cnt_reg);
                    m_last_next   = (32'(ld_cnt_reg) == 32'(BLOCK_WORDS - 1));
                    ld_cnt_next   = ld_cnt_reg + KW'(1);
                    if (32'(ld_cnt_reg) == 32'(BLOCK_WORDS - 1)) begin
                        state_next = fbc_pkg::S_IDLE;
                    end
                end
            end

            fbc_pkg::S_RESP: begin
                r_vld  = 1'b1;
                r_st   = res_st_reg;
                r_idx  = res_idx_reg;
                r_last = res_last_reg;
            end

            default: begin
                state_next = fbc_pkg::S_IDLE;
            end
        endcase

        // Single result: into the output register, or held until it frees
        if (r_vld) begin
            if (out_free) begin
                m_valid_next  = 1'b1;
                m_status_next = r_st;
                m_word_next   = '0;
                m_index_next  = r_idx;
                m_last_next   = r_last;
                state_next    = fbc_pkg::S_IDLE;
            end else begin
                res_st_next   = r_st;
                res_idx_next  = r_idx;
                res_last_next = r_last;
                state_next    = fbc_pkg::S_RESP;
            end
        end

        // Configuration writes clear the cache
        if (cfg_wr_en) begin
            case (cfg_index)
                fbc_pkg::CFG_SLOTS: begin
                    n_next    = CW'(fbc_pkg::clamp_slots(cfg_wdata, MAX_SLOTS));
                    cfg_clear = 1'b1;
                end
                fbc_pkg::CFG_ENABLE: begin
                    enable_next = cfg_wdata[0];
                    cfg_clear   = 1'b1;
                end
                default: begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
        if (cfg_clear) begin
            scan_ctl.clear = 1'b1;
            ptr_next       = '0;
            pend_slot_next = '0;
            pend_st_next   = fbc_pkg::ST_OK;
            pend_ok_next   = 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_word  = m_word_reg;
    assign m_out_index = m_index_reg;
    assign m_last      = m_last_reg;

endmodule

// ===== rtl/fbc_data_ram.sv =====
// Block data memory: one write port, one registered read port.
module fbc_data_ram #(
    parameter int DEPTH = fbc_pkg::MAX_SLOTS_DEF * fbc_pkg::BLOCK_WORDS_DEF,
    parameter int WIDTH = fbc_pkg::WORD_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fbc_tag_scan.sv =====
// Tag memory with clearing pass and sequential tag search engine.
module fbc_tag_scan #(
    parameter int MAX_SLOTS = fbc_pkg::MAX_SLOTS_DEF,
    localparam int SW = $clog2(MAX_SLOTS),
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  fbc_pkg::scan_ctl_t ctl,
    input  logic [SW-1:0]     wr_slot,
    input  logic [CW-1:0]     n_slots,
    output fbc_pkg::scan_rsp_t rsp,
    output logic [SW-1:0]     hit_slot
);

    fbc_pkg::tag_ent_t tag_mem [MAX_SLOTS];
    fbc_pkg::tag_ent_t rd_q_reg;

    logic          clr_act_reg;
    logic [SW-1:0] clr_cnt_reg;
    logic          scan_act_reg;
    logic [CW-1:0] iss_cnt_reg;
    logic          cmp_vld_reg;
    logic [SW-1:0] cmp_slot_reg;

    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    fbc_pkg::tag_ent_t mem_wdata;
    logic              rd_en;
    logic [SW-1:0]     rd_addr;
    logic              match;
    logic              done;

    // Write port: clearing pass has priority over tag installs
    always_comb begin
        mem_we    = clr_act_reg | ctl.wr_en;
        mem_waddr = clr_act_reg ? clr_cnt_reg : wr_slot;
        if (clr_act_reg) begin
            mem_wdata = '0;
        end else begin
            mem_wdata.valid = 1'b1;
            mem_wdata.disk  = ctl.disk;
            mem_wdata.block = ctl.block;
        end
    end

    // Search: one slot read per cycle, compare in the cycle after the read
    assign rd_en   = scan_act_reg && (iss_cnt_reg < n_slots);
    assign rd_addr = iss_cnt_reg[SW-1:0];
    assign match   = cmp_vld_reg && rd_q_reg.valid &&
                     (rd_q_reg.disk == ctl.disk) && (rd_q_reg.block == ctl.block);
    assign done    = scan_act_reg && (match || (cmp_vld_reg && (iss_cnt_reg >= n_slots)));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_q_reg <= tag_mem[rd_addr];
        end
    end

    // Clearing pass after reset and after each configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_act_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (ctl.clear) begin
            clr_act_reg <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_act_reg) begin
            if (clr_cnt_reg == SW'(MAX_SLOTS - 1)) begin
                clr_act_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + SW'(1);
            end
        end
    end

    // Scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_act_reg <= 1'b0;
            iss_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
        end else if (ctl.clear) begin
            scan_act_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else if (ctl.start) begin
            scan_act_reg <= 1'b1;
            iss_cnt_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
        end else if (scan_act_reg) begin
            if (rd_en) begin
                iss_cnt_reg <= iss_cnt_reg + CW'(1);
            end
            cmp_vld_reg <= rd_en;
            if (done) begin
                scan_act_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cmp_slot_reg <= rd_addr;
        end
    end

    assign rsp.busy = clr_act_reg;
    assign rsp.done = done;
    assign rsp.hit  = match;
    assign hit_slot = cmp_slot_reg;

endmodule
